// ----- design/spms_pkg.sv -----
// Shared types, codes and helpers for the step pulse motion sequencer.
package spms_pkg;

  localparam int COUNT_BITS = 16;
  localparam logic [COUNT_BITS-1:0] COUNT_MASK = '1;

  localparam int ARG_BITS = 16;
  localparam int AMOUNT_BITS = 15;
  localparam int DIV_BITS = 15;
  localparam int DIV_CNT_BITS = $clog2(DIV_BITS);

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);

  localparam logic [AMOUNT_BITS-1:0] SPEED_NUMERATOR_RESET = 15'd20250;
  localparam logic [AMOUNT_BITS-1:0] APPROACH_LIMIT_RESET = 15'd10000;
  localparam logic [AMOUNT_BITS-1:0] HALF_PERIOD_RESET = 15'd20;
  localparam logic [AMOUNT_BITS-1:0] RETRACT_RESET = 15'd2500;
  localparam logic [AMOUNT_BITS-1:0] START_RETRACT_RESET = 15'd1000;

  // Configuration register indexes.
  localparam logic CFG_SPEED_NUMERATOR = 1'b0;
  localparam logic CFG_APPROACH_LIMIT = 1'b1;

  // Command codes.
  localparam logic [3:0] OP_TICK = 4'd0;
  localparam logic [3:0] OP_MOVE = 4'd1;
  localparam logic [3:0] OP_OSCILLATE = 4'd2;
  localparam logic [3:0] OP_APPROACH = 4'd3;
  localparam logic [3:0] OP_APPROACH_RETRACT_ARG = 4'd4;
  localparam logic [3:0] OP_APPROACH_RETRACT_STORED = 4'd5;
  localparam logic [3:0] OP_RETRACT_START = 4'd6;
  localparam logic [3:0] OP_SET_SPEED = 4'd7;
  localparam logic [3:0] OP_SET_RETRACT = 4'd8;
  localparam logic [3:0] OP_SET_START_RETRACT = 4'd9;
  localparam logic [3:0] OP_STATUS = 4'd10;
  localparam logic [3:0] OP_VERSION = 4'd11;

  // Reply codes.
  localparam logic [2:0] REPLY_NONE = 3'd0;
  localparam logic [2:0] REPLY_DONE = 3'd1;
  localparam logic [2:0] REPLY_READY = 3'd2;
  localparam logic [2:0] REPLY_VERSION = 3'd3;
  localparam logic [2:0] REPLY_BUSY = 3'd4;

  typedef enum logic [2:0] {
    K_TICK,
    K_MOTION,
    K_SET_SPEED,
    K_SET_RETRACT,
    K_SET_START,
    K_STATUS,
    K_VERSION,
    K_IGNORE
  } kind_t;

  typedef struct packed {
    kind_t                  kind;
    logic [3:0]             op;
    logic                   touch;
    logic                   dir;
    logic                   arg_pos;
    logic [ARG_BITS-1:0]    mag;
    logic [AMOUNT_BITS-1:0] pos;
  } queue_entry_t;

  function automatic logic [COUNT_BITS-1:0] sat_count(input logic [ARG_BITS-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w > 32'(COUNT_MASK)) begin
      return COUNT_MASK;
    end
    return COUNT_BITS'(w);
  endfunction

endpackage

// ----- design/spms_if.sv -----
// Command and result channel interfaces of the motion sequencer.
interface spms_cmd_if;
  logic                 valid;
  logic                 ready;
  logic [3:0]           op;
  logic signed [15:0]   argument;
  logic                 touch_contact;

  modport source(output valid, op, argument, touch_contact, input ready);
  modport sink(input valid, op, argument, touch_contact, output ready);
endinterface

interface spms_rsp_if;
  logic       valid;
  logic       ready;
  logic       ccw_level;
  logic       cw_level;
  logic [2:0] reply;
  logic [3:0] reply_command;
  logic       busy_res;

  modport source(output valid, ccw_level, cw_level, reply, reply_command, busy_res,
                 input ready);
  modport sink(input valid, ccw_level, cw_level, reply, reply_command, busy_res,
               output ready);
endinterface

// ----- design/spms_fifo.sv -----
// Short queue of decoded items between the front and the back.
module spms_fifo (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  spms_pkg::queue_entry_t wr_data,
  output logic                  full,
  input  logic                  pop,
  output spms_pkg::queue_entry_t rd_data,
  output logic                  empty
);

  spms_pkg::queue_entry_t mem [spms_pkg::QUEUE_DEPTH];
  logic [spms_pkg::QPTR_BITS-1:0] wr_ptr;
  logic [spms_pkg::QPTR_BITS-1:0] rd_ptr;
  logic [spms_pkg::QPTR_BITS:0]   count;

  assign full = (count == (spms_pkg::QPTR_BITS+1)'(spms_pkg::QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ----- design/spms_div.sv -----
// Restoring divider for the half period, one quotient bit per cycle.
module spms_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [spms_pkg::DIV_BITS-1:0] dividend,
  input  logic [spms_pkg::DIV_BITS-1:0] divisor,
  output logic                          done,
  output logic [spms_pkg::DIV_BITS-1:0] quotient
);

  logic                              active;
  logic [spms_pkg::DIV_CNT_BITS-1:0] count;
  logic [spms_pkg::DIV_BITS-1:0]     rem;
  logic [spms_pkg::DIV_BITS-1:0]     quo;
  logic [spms_pkg::DIV_BITS-1:0]     dsr;
  logic [spms_pkg::DIV_BITS:0]       shifted;
  logic                              fits;

  assign shifted = {rem, quo[spms_pkg::DIV_BITS-1]};
  assign fits = (shifted >= {1'b0, dsr});
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (active) begin
      quo <= {quo[spms_pkg::DIV_BITS-2:0], fits};
      if (fits) begin
        rem <= spms_pkg::DIV_BITS'(shifted - {1'b0, dsr});
      end else begin
        rem <= spms_pkg::DIV_BITS'(shifted);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      count <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        count <= '0;
      end else if (active) begin
        count <= count + 1'b1;
        if (count == spms_pkg::DIV_CNT_BITS'(spms_pkg::DIV_BITS - 1)) begin
          active <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- design/spms_front.sv -----
// Front end: accepts command transactions and classifies them for the queue.
module spms_front (
  spms_cmd_if.sink               cmd,
  input  logic                   full,
  output logic                   push,
  output spms_pkg::queue_entry_t entry
);

  logic [15:0] arg_bits;
  logic        arg_pos;

  assign arg_bits = cmd.argument;
  assign arg_pos = !arg_bits[15] && (arg_bits != '0);

  assign cmd.ready = !full;
  assign push = cmd.valid && !full;

  always_comb begin
    entry.op = cmd.op;
    entry.touch = cmd.touch_contact;
    entry.arg_pos = arg_pos;
    entry.dir = !arg_pos;
    entry.mag = arg_bits[15] ? (~arg_bits + 16'd1) : arg_bits;
    entry.pos = arg_pos ? arg_bits[14:0] : '0;
    case (cmd.op)
      spms_pkg::OP_TICK:                    entry.kind = spms_pkg::K_TICK;
      spms_pkg::OP_MOVE,
      spms_pkg::OP_OSCILLATE,
      spms_pkg::OP_APPROACH,
      spms_pkg::OP_APPROACH_RETRACT_ARG,
      spms_pkg::OP_APPROACH_RETRACT_STORED,
      spms_pkg::OP_RETRACT_START:           entry.kind = spms_pkg::K_MOTION;
      spms_pkg::OP_SET_SPEED:               entry.kind = spms_pkg::K_SET_SPEED;
      spms_pkg::OP_SET_RETRACT:             entry.kind = spms_pkg::K_SET_RETRACT;
      spms_pkg::OP_SET_START_RETRACT:       entry.kind = spms_pkg::K_SET_START;
      spms_pkg::OP_STATUS:                  entry.kind = spms_pkg::K_STATUS;
      spms_pkg::OP_VERSION:                 entry.kind = spms_pkg::K_VERSION;
      default:                              entry.kind = spms_pkg::K_IGNORE;
    endcase
  end

endmodule

// ----- design/spms_back.sv -----
// Back end: runs the pulse sequencer state and registers each result.
module spms_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic                   cfg_index,
  input  logic [14:0]            cfg_data,
  input  logic                   empty,
  input  spms_pkg::queue_entry_t item,
  output logic                   pop,
  spms_rsp_if.source             rsp
);

  typedef enum logic [1:0] {
    ST_RUN = 2'b01,
    ST_DIV = 2'b10
  } state_t;

  state_t state, state_next;

  logic [14:0] speed_numerator;
  logic [14:0] approach_limit;

  logic [3:0]                      run_mode, run_mode_next;
  logic                            leg_index, leg_index_next;
  logic                            pulse_direction, pulse_direction_next;
  logic                            pulse_high_phase, pulse_high_phase_next;
  logic [spms_pkg::COUNT_BITS-1:0] pulses_left, pulses_left_next;
  logic [spms_pkg::COUNT_BITS-1:0] second_leg_pulses, second_leg_pulses_next;
  logic [14:0]                     phase_timer, phase_timer_next;
  logic [14:0]                     half_period, half_period_next;
  logic [14:0]                     retract_amount, retract_amount_next;
  logic [14:0]                     start_retract_amount, start_retract_amount_next;

  logic        out_valid;
  logic        load_out;
  logic [2:0]  reply;
  logic [3:0]  reply_cmd;
  logic        div_start;
  logic        div_done;
  logic [14:0] div_quotient;
  logic        do_advance;
  logic        busy_next;
  logic        high_next;
  logic [14:0] hp_eff;
  logic [15:0] timer_inc;

  spms_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (speed_numerator),
    .divisor  (item.pos),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign pop = (state == ST_RUN) && !empty && (!out_valid || rsp.ready);
  assign hp_eff = (half_period == '0) ? 15'd1 : half_period;
  assign timer_inc = {1'b0, phase_timer} + 16'd1;

  always_comb begin
    state_next = state;
    run_mode_next = run_mode;
    leg_index_next = leg_index;
    pulse_direction_next = pulse_direction;
    pulse_high_phase_next = pulse_high_phase;
    pulses_left_next = pulses_left;
    second_leg_pulses_next = second_leg_pulses;
    phase_timer_next = phase_timer;
    half_period_next = half_period;
    retract_amount_next = retract_amount;
    start_retract_amount_next = start_retract_amount;
    reply = spms_pkg::REPLY_NONE;
    reply_cmd = '0;
    load_out = 1'b0;
    div_start = 1'b0;
    do_advance = 1'b0;

    if (state == ST_DIV) begin
      if (div_done) begin
        half_period_next = (div_quotient == '0) ? 15'd1 : div_quotient;
        reply = spms_pkg::REPLY_DONE;
        reply_cmd = spms_pkg::OP_SET_SPEED;
        load_out = 1'b1;
        state_next = ST_RUN;
      end
    end else if (pop) begin
      load_out = 1'b1;
      if (item.kind == spms_pkg::K_TICK) begin
        if (run_mode != '0) begin
          if (timer_inc >= {1'b0, hp_eff}) begin
            phase_timer_next = '0;
            if (pulse_high_phase) begin
              pulse_high_phase_next = 1'b0;
            end else begin
              if (pulses_left != '0) begin
                pulses_left_next = pulses_left - 1'b1;
              end
              // Touch ends only the first leg of an approach command.
              if (!leg_index && item.touch &&
                  (run_mode == spms_pkg::OP_APPROACH ||
                   run_mode == spms_pkg::OP_APPROACH_RETRACT_ARG ||
                   run_mode == spms_pkg::OP_APPROACH_RETRACT_STORED)) begin
                pulses_left_next = '0;
              end
              do_advance = 1'b1;
            end
          end else begin
            phase_timer_next = timer_inc[14:0];
          end
        end
      end else if (item.kind != spms_pkg::K_IGNORE && run_mode != '0) begin
        reply = spms_pkg::REPLY_BUSY;
        reply_cmd = item.op;
      end else begin
        case (item.kind)
          spms_pkg::K_MOTION: begin
            leg_index_next = 1'b0;
            second_leg_pulses_next = '0;
            if (item.op == spms_pkg::OP_MOVE || item.op == spms_pkg::OP_OSCILLATE) begin
              pulse_direction_next = item.dir;
              pulses_left_next = spms_pkg::sat_count(item.mag);
              if (item.op == spms_pkg::OP_OSCILLATE) begin
                second_leg_pulses_next = spms_pkg::sat_count(item.mag);
              end
            end else if (item.op == spms_pkg::OP_RETRACT_START) begin
              pulse_direction_next = 1'b1;
              pulses_left_next = spms_pkg::sat_count({1'b0, start_retract_amount});
            end else begin
              pulse_direction_next = 1'b0;
              pulses_left_next = spms_pkg::sat_count({1'b0, approach_limit});
              if (item.op == spms_pkg::OP_APPROACH_RETRACT_ARG) begin
                second_leg_pulses_next = spms_pkg::sat_count({1'b0, item.pos});
              end else if (item.op == spms_pkg::OP_APPROACH_RETRACT_STORED) begin
                second_leg_pulses_next = spms_pkg::sat_count({1'b0, retract_amount});
              end
            end
            run_mode_next = item.op;
            do_advance = 1'b1;
          end
          spms_pkg::K_SET_SPEED: begin
            if (item.arg_pos) begin
              load_out = 1'b0;
              div_start = 1'b1;
              state_next = ST_DIV;
            end else begin
              half_period_next = 15'd1;
              reply = spms_pkg::REPLY_DONE;
              reply_cmd = item.op;
            end
          end
          spms_pkg::K_SET_RETRACT: begin
            retract_amount_next = item.pos;
            reply = spms_pkg::REPLY_DONE;
            reply_cmd = item.op;
          end
          spms_pkg::K_SET_START: begin
            start_retract_amount_next = item.pos;
            reply = spms_pkg::REPLY_DONE;
            reply_cmd = item.op;
          end
          spms_pkg::K_STATUS: begin
            reply = spms_pkg::REPLY_READY;
            reply_cmd = item.op;
          end
          spms_pkg::K_VERSION: begin
            reply = spms_pkg::REPLY_VERSION;
            reply_cmd = item.op;
          end
          default: begin
          end
        endcase
      end

      // Start the next pulse, switch to the second leg, or finish the motion.
      if (do_advance) begin
        if (pulses_left_next != '0) begin
          pulse_high_phase_next = 1'b1;
          phase_timer_next = '0;
        end else if (!leg_index_next && second_leg_pulses_next != '0) begin
          leg_index_next = 1'b1;
          pulse_direction_next = !pulse_direction_next;
          pulses_left_next = second_leg_pulses_next;
          second_leg_pulses_next = '0;
          pulse_high_phase_next = 1'b1;
          phase_timer_next = '0;
        end else begin
          reply = spms_pkg::REPLY_DONE;
          reply_cmd = run_mode_next;
          run_mode_next = '0;
          pulse_high_phase_next = 1'b0;
          phase_timer_next = '0;
          leg_index_next = 1'b0;
        end
      end
    end

    busy_next = (run_mode_next != '0);
    high_next = busy_next && pulse_high_phase_next;
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      rsp.ccw_level <= high_next && !pulse_direction_next;
      rsp.cw_level <= high_next && pulse_direction_next;
      rsp.reply <= reply;
      rsp.reply_command <= reply_cmd;
      rsp.busy_res <= busy_next;
    end
  end

  assign rsp.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_RUN;
      out_valid <= 1'b0;
      speed_numerator <= spms_pkg::SPEED_NUMERATOR_RESET;
      approach_limit <= spms_pkg::APPROACH_LIMIT_RESET;
      run_mode <= '0;
      leg_index <= 1'b0;
      pulse_direction <= 1'b0;
      pulse_high_phase <= 1'b0;
      pulses_left <= '0;
      second_leg_pulses <= '0;
      phase_timer <= '0;
      half_period <= spms_pkg::HALF_PERIOD_RESET;
      retract_amount <= spms_pkg::RETRACT_RESET;
      start_retract_amount <= spms_pkg::START_RETRACT_RESET;
    end else begin
      state <= state_next;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_write) begin
        case (cfg_index)
          spms_pkg::CFG_SPEED_NUMERATOR: speed_numerator <= cfg_data;
          spms_pkg::CFG_APPROACH_LIMIT:  approach_limit <= cfg_data;
          default: begin
          end
        endcase
      end
      run_mode <= run_mode_next;
      leg_index <= leg_index_next;
      pulse_direction <= pulse_direction_next;
      pulse_high_phase <= pulse_high_phase_next;
      pulses_left <= pulses_left_next;
      second_leg_pulses <= second_leg_pulses_next;
      phase_timer <= phase_timer_next;
      half_period <= half_period_next;
      retract_amount <= retract_amount_next;
      start_retract_amount <= start_retract_amount_next;
    end
  end

  a_no_pop_while_dividing: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> !pop)
    else $error("queue popped while the divider is running");

  a_div_done_in_div_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_DIV))
    else $error("divider finished outside of a speed update");

  a_idle_pins_low: assert property (@(posedge clk) disable iff (rst)
    (run_mode == '0) |-> !pulse_high_phase)
    else $error("pulse high phase held with no motion running");

  a_second_leg_cleared: assert property (@(posedge clk) disable iff (rst)
    leg_index |-> (second_leg_pulses == '0))
    else $error("second leg count left over after the leg switch");

  a_half_period_nonzero: assert property (@(posedge clk) disable iff (rst)
    half_period != '0)
    else $error("half period became zero");

endmodule

// ----- design/step_pulse_motion_sequencer_unit.sv -----
// Top level of the step pulse motion sequencer.
//
// The cmd channel takes one transaction per command or per 1 us tick (op 0),
// with a signed argument and the needle touch level. The rsp channel gives
// exactly one result transaction per command transaction: the cw and ccw
// step pin levels after that item, a reply code with the op it concerns,
// and the busy flag of the running motion.
// The front end classifies each command and places it in a four-entry queue;
// the back end retires one queued item per cycle into the result register
// while rsp is not stalled and no speed division runs. A command passes
// through the queue and then the result register before its result is valid.
// A set-speed command with a positive argument holds the back end until the
// 15-step restoring divider is done, and only then loads its result.
// When rsp is stalled the result register holds, the back end stops, and
// cmd keeps accepting until the queue is full.
// Configuration writes (index 0 speed numerator, index 1 approach limit)
// take effect on the next cycle and belong in idle periods.
// Synchronous reset empties the queue, drops any result, stops motion and
// restores the default speed and retract amounts; pin levels are not reset.
module step_pulse_motion_sequencer_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [14:0] cfg_data,
  spms_cmd_if.sink    cmd,
  spms_rsp_if.source  rsp
);

  spms_pkg::queue_entry_t push_entry;
  spms_pkg::queue_entry_t pop_entry;
  logic                   push;
  logic                   pop;
  logic                   full;
  logic                   empty;

  spms_front u_front (
    .cmd   (cmd),
    .full  (full),
    .push  (push),
    .entry (push_entry)
  );

  spms_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (push_entry),
    .full    (full),
    .pop     (pop),
    .rd_data (pop_entry),
    .empty   (empty)
  );

  spms_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .empty     (empty),
    .item      (pop_entry),
    .pop       (pop),
    .rsp       (rsp)
  );

endmodule
